[design/bbc_pkg.sv]
// shared types and constants of the bracket balance checker
package bbc_pkg;

    // result status codes
    typedef enum logic [2:0] {
        ST_SCAN         = 3'd0,
        ST_OK           = 3'd1,
        ST_BAD_CLOSER   = 3'd2,
        ST_OPEN_STRING  = 3'd3,
        ST_BAD_CHAR     = 3'd4,
        ST_OPEN_COMMENT = 3'd5,
        ST_UNCLOSED     = 3'd6,
        ST_OVERFLOW     = 3'd7
    } status_t;

    // bracket kinds
    typedef enum logic [1:0] {
        KIND_ROUND  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_CURLY  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    localparam int KIND_BITS = 2;

    // lexer modes, one-hot
    typedef enum logic [9:0] {
        M_CODE       = 10'b00_0000_0001,
        M_SLASH      = 10'b00_0000_0010,
        M_LINE_CMT   = 10'b00_0000_0100,
        M_BLOCK      = 10'b00_0000_1000,
        M_BLOCK_STAR = 10'b00_0001_0000,
        M_STR        = 10'b00_0010_0000,
        M_STR_ESC    = 10'b00_0100_0000,
        M_CHR_FIRST  = 10'b00_1000_0000,
        M_CHR_ESC    = 10'b01_0000_0000,
        M_CHR_CLOSE  = 10'b10_0000_0000
    } lex_mode_t;

    // character codes
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_SLASH     = 8'h2F;

    // stack status seen by the lexer
    typedef struct packed {
        logic  empty;
        logic  full;
        kind_t top_kind;
    } stack_info_t;

    // stack command from the lexer
    typedef struct packed {
        logic  push;
        logic  pop;
        kind_t kind;
    } stack_cmd_t;

endpackage

[design/bbc_if.sv]
// request and result channels of the bracket balance checker
interface bbc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       start_of_text;
    logic       end_of_text;

    modport source (output valid, output char_code, output start_of_text,
                    output end_of_text, input ready);
    modport sink (input valid, input char_code, input start_of_text,
                  input end_of_text, output ready);
endinterface

interface bbc_out_if #(
    parameter int LINE_W  = 16,
    parameter int COL_W   = 12,
    parameter int DEPTH_W = 7
);
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [LINE_W-1:0]  error_line;
    logic [COL_W-1:0]   error_column;
    logic [DEPTH_W-1:0] open_depth;

    modport source (output valid, output status, output error_line,
                    output error_column, output open_depth, input ready);
    modport sink (input valid, input status, input error_line,
                  input error_column, input open_depth, output ready);
endinterface

[design/bracket_balance_checker_top.sv]
// top level of the bracket balance checker
// throughput: one byte per clock while the output slot is free or being emptied;
// results are registered in the output register; the stack keeps its top two
// entries in registers and prefetches the third, so a pop never waits on memory
// reset: lexer in code mode, line 1, column 0, empty stack, status scanning;
// stack memory is not cleared, every entry used is written first in the same text
module bracket_balance_checker_top #(
    parameter int MAX_NESTING = 64,
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12
) (
    input  logic      clk,
    input  logic      rst_n,
    bbc_in_if.sink    text,
    bbc_out_if.source result
);
    localparam int DEPTH_W = $clog2(MAX_NESTING + 1);

    logic accept;

    bbc_pkg::stack_cmd_t    cmd;
    bbc_pkg::stack_info_t   info;
    logic [LINE_BITS-1:0]   top_line, pos_line, err_line_next;
    logic [COLUMN_BITS-1:0] top_column, pos_column, err_column_next;
    logic [DEPTH_W-1:0]     depth_next;
    bbc_pkg::status_t       status_next;

    // output register
    logic                   res_valid_reg;
    bbc_pkg::status_t       res_status_reg;
    logic [LINE_BITS-1:0]   res_line_reg;
    logic [COLUMN_BITS-1:0] res_column_reg;
    logic [DEPTH_W-1:0]     res_depth_reg;

    // a new request is taken whenever the output slot is free or being emptied
    assign text.ready = !res_valid_reg || result.ready;
    assign accept     = text.valid && text.ready;

    // lexer: mode, position counters and the latched first error
    bbc_lexer #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_lexer (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .char_code       (text.char_code),
        .start_of_text   (text.start_of_text),
        .end_of_text     (text.end_of_text),
        .info            (info),
        .top_line        (top_line),
        .top_column      (top_column),
        .cmd             (cmd),
        .pos_line        (pos_line),
        .pos_column      (pos_column),
        .status_next     (status_next),
        .err_line_next   (err_line_next),
        .err_column_next (err_column_next)
    );

    // stack of open brackets with their positions
    bbc_stack #(
        .MAX_NESTING (MAX_NESTING),
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_stack (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (accept && text.start_of_text),
        .cmd         (cmd),
        .push_line   (pos_line),
        .push_column (pos_column),
        .info        (info),
        .top_line    (top_line),
        .top_column  (top_column),
        .depth_next  (depth_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // payload of the result, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_status_reg <= status_next;
            res_line_reg   <= err_line_next;
            res_column_reg <= err_column_next;
            res_depth_reg  <= depth_next;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.status       = res_status_reg;
    assign result.error_line   = res_line_reg;
    assign result.error_column = res_column_reg;
    assign result.open_depth   = res_depth_reg;
endmodule

[design/bbc_stack.sv]
// bracket stack: top and next entry in registers, every entry also in a memory
module bbc_stack #(
    parameter int MAX_NESTING = 64,
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 clear,
    input  bbc_pkg::stack_cmd_t                  cmd,
    input  logic [LINE_BITS-1:0]                 push_line,
    input  logic [COLUMN_BITS-1:0]               push_column,
    output bbc_pkg::stack_info_t                 info,
    output logic [LINE_BITS-1:0]                 top_line,
    output logic [COLUMN_BITS-1:0]               top_column,
    output logic [$clog2(MAX_NESTING+1)-1:0]     depth_next
);
    localparam int CNT_W   = $clog2(MAX_NESTING + 1);
    localparam int ADDR_W  = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
    localparam int ENTRY_W = bbc_pkg::KIND_BITS + LINE_BITS + COLUMN_BITS;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_NESTING);
    localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO      = CNT_W'(2);
    localparam logic [CNT_W-1:0] THREE    = CNT_W'(3);
    localparam logic [CNT_W-1:0] FOUR     = CNT_W'(4);

    logic [ENTRY_W-1:0] mem [0:MAX_NESTING-1];

    logic [CNT_W-1:0]   count_reg, count_next, count_eff;
    logic [ENTRY_W-1:0] top_reg, top_next;
    logic [ENTRY_W-1:0] below_reg, below_next;
    logic [ENTRY_W-1:0] rd_reg;       // entry two below the top
    logic [ENTRY_W-1:0] new_entry;
    logic [CNT_W-1:0]   rd_cnt;

    assign count_eff = clear ? '0 : count_reg;
    assign new_entry = {cmd.kind, push_line, push_column};

    assign info.empty    = (count_eff == '0);
    assign info.full     = (count_eff == FULL_CNT);
    assign info.top_kind = bbc_pkg::kind_t'(top_reg[ENTRY_W-1 -: bbc_pkg::KIND_BITS]);
    assign top_line      = top_reg[COLUMN_BITS +: LINE_BITS];
    assign top_column    = top_reg[COLUMN_BITS-1:0];
    assign depth_next    = count_next;

    always_comb
    begin
        count_next = count_eff;
        top_next   = top_reg;
        below_next = below_reg;
        rd_cnt     = count_eff - THREE;
        if (cmd.push)
        begin
            count_next = count_eff + ONE;
            top_next   = new_entry;
            below_next = top_reg;
            rd_cnt     = count_eff - TWO;
        end
        else if (cmd.pop)
        begin
            count_next = count_eff - ONE;
            top_next   = below_reg;
            below_next = rd_reg;
            rd_cnt     = count_eff - FOUR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg   <= top_next;
        below_reg <= below_next;
    end

    // memory holds every pushed entry at its depth index
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[count_eff[ADDR_W-1:0]] <= new_entry;
        end
        rd_reg <= mem[rd_cnt[ADDR_W-1:0]];
    end
endmodule

[design/bbc_lexer.sv]
// lexer state, position tracking and latched status
module bbc_lexer #(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             char_code,
    input  logic                   start_of_text,
    input  logic                   end_of_text,
    input  bbc_pkg::stack_info_t   info,
    input  logic [LINE_BITS-1:0]   top_line,
    input  logic [COLUMN_BITS-1:0] top_column,
    output bbc_pkg::stack_cmd_t    cmd,
    output logic [LINE_BITS-1:0]   pos_line,
    output logic [COLUMN_BITS-1:0] pos_column,
    output bbc_pkg::status_t       status_next,
    output logic [LINE_BITS-1:0]   err_line_next,
    output logic [COLUMN_BITS-1:0] err_column_next
);
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

    bbc_pkg::lex_mode_t     mode_reg, mode_next, mode_eff;
    logic [LINE_BITS-1:0]   line_reg, line_next, line_eff;
    logic [COLUMN_BITS-1:0] col_reg, col_next, col_eff;
    bbc_pkg::status_t       st_reg, st_eff;
    logic [LINE_BITS-1:0]   eline_reg, eline_eff;
    logic [COLUMN_BITS-1:0] ecol_reg, ecol_eff;

    logic                   do_code, is_open, is_close, push_c, pop_c, raise;
    bbc_pkg::kind_t         kind;
    bbc_pkg::status_t       raise_st;
    logic [LINE_BITS-1:0]   raise_line;
    logic [COLUMN_BITS-1:0] raise_col;

    assign cmd.push   = accept & push_c;
    assign cmd.pop    = accept & pop_c;
    assign cmd.kind   = kind;
    assign pos_line   = line_eff;

    always_comb
    begin
        mode_eff   = start_of_text ? bbc_pkg::M_CODE : mode_reg;
        line_eff   = start_of_text ? LINE_ONE : line_reg;
        col_eff    = start_of_text ? '0 : col_reg;
        st_eff     = start_of_text ? bbc_pkg::ST_SCAN : st_reg;
        eline_eff  = start_of_text ? '0 : eline_reg;
        ecol_eff   = start_of_text ? '0 : ecol_reg;
        pos_column = (col_eff != COL_MAX) ? col_eff + COL_ONE : COL_MAX;

        mode_next  = mode_eff;
        line_next  = line_eff;
        col_next   = col_eff;
        do_code    = 1'b0;
        is_open    = 1'b0;
        is_close   = 1'b0;
        push_c     = 1'b0;
        pop_c      = 1'b0;
        kind       = bbc_pkg::KIND_NONE;
        raise      = 1'b0;
        raise_st   = bbc_pkg::ST_SCAN;
        raise_line = line_eff;
        raise_col  = pos_column;

        if (st_eff == bbc_pkg::ST_SCAN)
        begin
            if (end_of_text)
            begin
                raise = 1'b1;
                unique case (mode_eff)
                    bbc_pkg::M_STR, bbc_pkg::M_STR_ESC:
                        raise_st = bbc_pkg::ST_OPEN_STRING;
                    bbc_pkg::M_CHR_FIRST, bbc_pkg::M_CHR_ESC, bbc_pkg::M_CHR_CLOSE:
                        raise_st = bbc_pkg::ST_BAD_CHAR;
                    bbc_pkg::M_BLOCK, bbc_pkg::M_BLOCK_STAR:
                        raise_st = bbc_pkg::ST_OPEN_COMMENT;
                    default:
                    begin
                        if (!info.empty)
                        begin
                            raise_st   = bbc_pkg::ST_UNCLOSED;
                            raise_line = top_line;
                            raise_col  = top_column;
                        end
                        else
                        begin
                            raise_st   = bbc_pkg::ST_OK;
                            raise_line = '0;
                            raise_col  = '0;
                        end
                    end
                endcase
            end
            else
            begin
                unique case (mode_eff)
                    bbc_pkg::M_SLASH:
                    begin
                        if (char_code == bbc_pkg::CH_SLASH)
                            mode_next = bbc_pkg::M_LINE_CMT;
                        else if (char_code == bbc_pkg::CH_STAR)
                            mode_next = bbc_pkg::M_BLOCK;
                        else
                        begin
                            mode_next = bbc_pkg::M_CODE;
                            do_code   = 1'b1;
                        end
                    end
                    bbc_pkg::M_LINE_CMT:
                        if (char_code == bbc_pkg::CH_NEWLINE)
                            mode_next = bbc_pkg::M_CODE;
                    bbc_pkg::M_BLOCK:
                        if (char_code == bbc_pkg::CH_STAR)
                            mode_next = bbc_pkg::M_BLOCK_STAR;
                    bbc_pkg::M_BLOCK_STAR:
                    begin
                        if (char_code == bbc_pkg::CH_SLASH)
                            mode_next = bbc_pkg::M_CODE;
                        else if (char_code != bbc_pkg::CH_STAR)
                            mode_next = bbc_pkg::M_BLOCK;
                    end
                    bbc_pkg::M_STR:
                    begin
                        if (char_code == bbc_pkg::CH_NEWLINE)
                        begin
                            raise    = 1'b1;
                            raise_st = bbc_pkg::ST_OPEN_STRING;
                        end
                        else if (char_code == bbc_pkg::CH_BACKSLASH)
                            mode_next = bbc_pkg::M_STR_ESC;
                        else if (char_code == bbc_pkg::CH_DQUOTE)
                            mode_next = bbc_pkg::M_CODE;
                    end
                    bbc_pkg::M_STR_ESC:
                    begin
                        if (char_code == bbc_pkg::CH_NEWLINE)
                        begin
                            raise    = 1'b1;
                            raise_st = bbc_pkg::ST_OPEN_STRING;
                        end
                        else
                            mode_next = bbc_pkg::M_STR;
                    end
                    bbc_pkg::M_CHR_FIRST:
                    begin
                        if (char_code == bbc_pkg::CH_NEWLINE ||
                            char_code == bbc_pkg::CH_SQUOTE)
                        begin
                            raise    = 1'b1;
                            raise_st = bbc_pkg::ST_BAD_CHAR;
                        end
                        else if (char_code == bbc_pkg::CH_BACKSLASH)
                            mode_next = bbc_pkg::M_CHR_ESC;
                        else
                            mode_next = bbc_pkg::M_CHR_CLOSE;
                    end
                    bbc_pkg::M_CHR_ESC:
                    begin
                        if (char_code == bbc_pkg::CH_NEWLINE)
                        begin
                            raise    = 1'b1;
                            raise_st = bbc_pkg::ST_BAD_CHAR;
                        end
                        else
                            mode_next = bbc_pkg::M_CHR_CLOSE;
                    end
                    bbc_pkg::M_CHR_CLOSE:
                    begin
                        if (char_code == bbc_pkg::CH_SQUOTE)
                            mode_next = bbc_pkg::M_CODE;
                        else
                        begin
                            raise    = 1'b1;
                            raise_st = bbc_pkg::ST_BAD_CHAR;
                        end
                    end
                    default:
                    begin
                        mode_next = bbc_pkg::M_CODE;
                        do_code   = 1'b1;
                    end
                endcase

                if (do_code)
                begin
                    unique case (char_code)
                        bbc_pkg::CH_DQUOTE:   mode_next = bbc_pkg::M_STR;
                        bbc_pkg::CH_SQUOTE:   mode_next = bbc_pkg::M_CHR_FIRST;
                        bbc_pkg::CH_SLASH:    mode_next = bbc_pkg::M_SLASH;
                        bbc_pkg::CH_LPAREN:
                        begin
                            is_open = 1'b1;
                            kind    = bbc_pkg::KIND_ROUND;
                        end
                        bbc_pkg::CH_LBRACKET:
                        begin
                            is_open = 1'b1;
                            kind    = bbc_pkg::KIND_SQUARE;
                        end
                        bbc_pkg::CH_LBRACE:
                        begin
                            is_open = 1'b1;
                            kind    = bbc_pkg::KIND_CURLY;
                        end
                        bbc_pkg::CH_RPAREN:
                        begin
                            is_close = 1'b1;
                            kind     = bbc_pkg::KIND_ROUND;
                        end
                        bbc_pkg::CH_RBRACKET:
                        begin
                            is_close = 1'b1;
                            kind     = bbc_pkg::KIND_SQUARE;
                        end
                        bbc_pkg::CH_RBRACE:
                        begin
                            is_close = 1'b1;
                            kind     = bbc_pkg::KIND_CURLY;
                        end
                        default:
                        begin
                        end
                    endcase
                end

                if (is_open)
                begin
                    if (info.full)
                    begin
                        raise    = 1'b1;
                        raise_st = bbc_pkg::ST_OVERFLOW;
                    end
                    else
                        push_c = 1'b1;
                end
                if (is_close)
                begin
                    if (info.empty || info.top_kind != kind)
                    begin
                        raise    = 1'b1;
                        raise_st = bbc_pkg::ST_BAD_CLOSER;
                    end
                    else
                        pop_c = 1'b1;
                end

                // position advance
                if (char_code == bbc_pkg::CH_NEWLINE)
                begin
                    if (line_eff != LINE_MAX)
                        line_next = line_eff + LINE_ONE;
                    col_next = '0;
                end
                else
                    col_next = pos_column;
            end
        end

        status_next     = raise ? raise_st : st_eff;
        err_line_next   = raise ? raise_line : eline_eff;
        err_column_next = raise ? raise_col : ecol_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= bbc_pkg::M_CODE;
            line_reg  <= LINE_ONE;
            col_reg   <= '0;
            st_reg    <= bbc_pkg::ST_SCAN;
            eline_reg <= '0;
            ecol_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            st_reg    <= status_next;
            eline_reg <= err_line_next;
            ecol_reg  <= err_column_next;
        end
    end
endmodule
